// ===== rtl/fqs_pkg.sv =====
// shared types and constants of the flight id queue with search
package fqs_pkg;

  // fixed widths of the channel fields
  localparam int unsigned ID_PORT_W  = 16;
  localparam int unsigned POS_PORT_W = 4;
  localparam int unsigned CNT_PORT_W = 5;

  // request kinds
  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } fqs_req_t;

  // input request as it arrives on the port
  typedef struct packed {
    logic [1:0]           req_type;
    logic [ID_PORT_W-1:0] flight_id;
  } fqs_in_t;

  // result as it leaves on the port
  typedef struct packed {
    logic                  ok;
    logic [ID_PORT_W-1:0]  data_out;
    logic [POS_PORT_W-1:0] position;
    logic [ID_PORT_W-1:0]  front_id;
    logic [CNT_PORT_W-1:0] entry_count;
    logic                  is_empty;
  } fqs_out_t;

  // decoded command held in the command queue
  typedef struct packed {
    fqs_req_t             op;
    logic [ID_PORT_W-1:0] flight_id;
  } fqs_cmd_t;

  // handshake between command queue and execution engine
  typedef struct packed {
    logic     valid;
    fqs_cmd_t cmd;
  } fqs_cmdq_t;

  // execution engine states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DEQ_RD = 2'd1,
    ST_SCAN   = 2'd2
  } fqs_state_t;

endpackage

// ===== rtl/fifo_queue_with_search_top.sv =====
// top level of the flight id queue with search
//
// Requests (enqueue, dequeue, search, clear) arrive on in_valid/in_stall/in_data
// and each gives exactly one result on out_valid/out_stall/out_data, in order.
// A request is taken when valid is high and stall is low on a rising edge.
// Accepted requests wait in a two-entry command queue; the engine takes one
// per cycle when idle and its result register is free or being drained.
// Enqueue, clear, a failed request and a dequeue that empties the queue
// register their result when the engine takes the command; a dequeue that
// leaves entries first reads the new front entry from the ring ram in the
// DEQ_RD state. out_valid comes straight from the result register.
// A search reads one ring entry per cycle through the ram read port and
// compares it the next cycle, ending at the first hit or after the last
// entry. Back-to-back enqueues run at one per cycle while out_stall stays
// low; the single ram read port sets the search rate.
// Reset (rst_n low, synchronous) empties the queue: head, tail and count go
// to zero, no result is pending. Ring contents are not cleared.
// While out_stall is high the result holds and up to two further requests
// are buffered before in_stall rises.
module fifo_queue_with_search_top #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fqs_pkg::fqs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fqs_pkg::fqs_out_t out_data
);
  import fqs_pkg::*;

  fqs_cmdq_t cmdq;
  logic      cmd_pop;

  // request intake and command queue
  fqs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_out    (cmdq),
    .q_pop    (cmd_pop)
  );

  // execution engine
  fqs_back #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (cmdq),
    .q_pop     (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/fqs_ram.sv =====
// generic single write port ram with registered read
module fqs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fqs_front.sv =====
// request intake: decodes requests into commands and buffers two of them
module fqs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fqs_pkg::fqs_in_t  in_data,
  output fqs_pkg::fqs_cmdq_t q_out,
  input  logic              q_pop
);
  import fqs_pkg::*;

  fqs_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  fqs_cmd_t   cmd_dec;

  // decode the request into a command
  always_comb begin
    cmd_dec.op        = fqs_req_t'(in_data.req_type);
    cmd_dec.flight_id = in_data.flight_id;
  end

  // queue bookkeeping
  assign in_stall = cnt_r[1];
  assign push     = in_valid & ~in_stall;

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // command slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_dec;
    end
  end

  // head of queue toward the engine
  always_comb begin
    q_out.valid = (cnt_r != 2'd0);
    q_out.cmd   = slot_r[rd_ptr_r];
  end

endmodule

// ===== rtl/fqs_back.sv =====
// execution engine: ring buffer, pointers, search scan and result register
module fqs_back #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fqs_pkg::fqs_cmdq_t q_in,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fqs_pkg::fqs_out_t  out_data
);
  import fqs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fqs_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] front_r, front_nxt;
  logic [ID_WIDTH-1:0] sid_r, sid_nxt;
  logic [PTR_W-1:0]    addr_r, addr_nxt;
  logic [CNT_W-1:0]    kiss_r, kiss_nxt;
  logic [CNT_W-1:0]    kcmp_r, kcmp_nxt;
  logic                rdv_r, rdv_nxt;
  logic                out_valid_r, out_valid_nxt;
  fqs_out_t            out_data_r;

  logic                take;
  logic [ID_WIDTH-1:0] cmd_id;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                res_fire;
  logic                res_ok;
  logic                res_deq;
  logic [CNT_W-1:0]    res_pos;
  logic [ID_PORT_W-1:0] front_ext;
  logic [ID_PORT_W-1:0] data_ext;
  logic [31:0]         pos_wide;
  logic [31:0]         cnt_wide;
  logic                hit;
  logic                last_cmp;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // request id in stored width
  for (genvar g = 0; g < ID_WIDTH; g++) begin : g_cmd_id
    if (g < ID_PORT_W) begin : g_bit
      assign cmd_id[g] = q_in.cmd.flight_id[g];
    end else begin : g_zero
      assign cmd_id[g] = 1'b0;
    end
  end

  // stored ids widened to port width
  for (genvar g = 0; g < ID_PORT_W; g++) begin : g_ext
    if (g < ID_WIDTH) begin : g_bit
      assign front_ext[g] = front_nxt[g];
      assign data_ext[g]  = front_r[g];
    end else begin : g_zero
      assign front_ext[g] = 1'b0;
      assign data_ext[g]  = 1'b0;
    end
  end

  // take a command when idle and the result slot is or becomes free
  assign take  = (state_r == ST_IDLE) & q_in.valid & (~out_valid_r | ~out_stall);
  assign q_pop = take;

  // scan compare of the entry read last cycle
  assign hit      = rdv_r & (ram_rdata == sid_r);
  assign last_cmp = rdv_r & (kcmp_r == count_r - 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_in.cmd.op == REQ_DEQ && count_r > CNT_W'(1)) begin
            state_nxt = ST_DEQ_RD;
          end else if (q_in.cmd.op == REQ_SEARCH && count_r != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_DEQ_RD: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit || last_cmp) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and result generation
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    front_nxt = front_r;
    sid_nxt   = sid_r;
    addr_nxt  = addr_r;
    kiss_nxt  = kiss_r;
    kcmp_nxt  = kcmp_r;
    rdv_nxt   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = addr_r;
    res_fire  = 1'b0;
    res_ok    = 1'b0;
    res_deq   = 1'b0;
    res_pos   = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (q_in.cmd.op)
            REQ_ENQ: begin
              res_fire = 1'b1;
              if (count_r != CNT_W'(DEPTH)) begin
                ram_we    = 1'b1;
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + 1'b1;
                res_ok    = 1'b1;
                if (count_r == '0) begin
                  front_nxt = cmd_id;
                end
              end
            end
            REQ_DEQ: begin
              ram_raddr = ptr_inc(head_r);
              if (count_r != '0) begin
                head_nxt  = ptr_inc(head_r);
                count_nxt = count_r - 1'b1;
              end
              // with entries left the new front is read first
              if (count_r <= CNT_W'(1)) begin
                res_fire = 1'b1;
                res_ok   = (count_r != '0);
                res_deq  = (count_r != '0);
              end
            end
            REQ_SEARCH: begin
              sid_nxt  = cmd_id;
              addr_nxt = head_r;
              kiss_nxt = '0;
              if (count_r == '0) begin
                res_fire = 1'b1;
              end
            end
            REQ_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              res_fire  = 1'b1;
              res_ok    = 1'b1;
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ_RD: begin
        front_nxt = ram_rdata;
        res_fire  = 1'b1;
        res_ok    = 1'b1;
        res_deq   = 1'b1;
      end
      ST_SCAN: begin
        // issue the next read while comparing the previous one
        if (kiss_r != count_r) begin
          addr_nxt = ptr_inc(addr_r);
          kiss_nxt = kiss_r + 1'b1;
          kcmp_nxt = kiss_r;
          rdv_nxt  = 1'b1;
        end
        if (hit) begin
          res_fire = 1'b1;
          res_ok   = 1'b1;
          res_pos  = kcmp_r;
        end else if (last_cmp) begin
          res_fire = 1'b1;
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  // result register
  assign pos_wide      = 32'(res_pos);
  assign cnt_wide      = 32'(count_nxt);
  assign out_valid_nxt = res_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_data_r.ok          <= res_ok;
      out_data_r.data_out    <= res_deq ? data_ext : '0;
      out_data_r.position    <= pos_wide[POS_PORT_W-1:0];
      out_data_r.front_id    <= (count_nxt == '0) ? '0 : front_ext;
      out_data_r.entry_count <= cnt_wide[CNT_PORT_W-1:0];
      out_data_r.is_empty    <= (count_nxt == '0);
    end
  end

  // control and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      kiss_r      <= '0;
      kcmp_r      <= '0;
      addr_r      <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      kiss_r      <= kiss_nxt;
      kcmp_r      <= kcmp_nxt;
      addr_r      <= addr_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    sid_r   <= sid_nxt;
  end

  // entry ring
  fqs_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (cmd_id),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/tb.sv =====
// testbench for the flight id queue with search: shadow queue scoreboard and random traffic
`timescale 1ns / 1ps

module tb;
  import fqs_pkg::*;

  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  // shadow copy of the ring and the replies it predicts
  class flight_queue_shadow;
    logic [ID_PORT_W-1:0] ring [QDEPTH];
    int unsigned          head;
    int unsigned          tail;
    int unsigned          held;
    fqs_out_t             awaited_replies [$];
    int unsigned          failures;

    function new();
      head     = 0;
      tail     = 0;
      held     = 0;
      failures = 0;
    endfunction

    function int unsigned wrap_next(int unsigned idx);
      return (idx + 1 >= QDEPTH) ? 0 : idx + 1;
    endfunction

    // apply one accepted request and queue the reply it must give
    function void predict_reply(fqs_in_t r);
      fqs_out_t    rep;
      int unsigned idx;
      rep = '0;
      case (r.req_type)
        REQ_ENQ: begin
          if (held < QDEPTH) begin
            ring[tail] = r.flight_id;
            tail       = wrap_next(tail);
            held++;
            rep.ok = 1'b1;
          end
        end
        REQ_DEQ: begin
          if (held != 0) begin
            rep.data_out = ring[head];
            head         = wrap_next(head);
            held--;
            rep.ok = 1'b1;
          end
        end
        REQ_SEARCH: begin
          idx = head;
          for (int unsigned k = 0; k < held; k++) begin
            if (ring[idx] == r.flight_id) begin
              rep.ok       = 1'b1;
              rep.position = k[POS_PORT_W-1:0];
              break;
            end
            idx = wrap_next(idx);
          end
        end
        REQ_CLEAR: begin
          head   = 0;
          tail   = 0;
          held   = 0;
          rep.ok = 1'b1;
        end
      endcase
      if (held != 0) rep.front_id = ring[head];
      rep.entry_count = held[CNT_PORT_W-1:0];
      rep.is_empty    = (held == 0);
      awaited_replies.push_back(rep);
    endfunction

    function void cmp_field(string what, logic [ID_PORT_W-1:0] want, logic [ID_PORT_W-1:0] got);
      if (got !== want) begin
        $display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
        failures++;
      end
    endfunction

    // compare one delivered reply against the oldest prediction
    function void check_reply(fqs_out_t got);
      fqs_out_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t unexpected reply: expected none, got %0h", $time, got);
        failures++;
        return;
      end
      want = awaited_replies.pop_front();
      cmp_field("ok", want.ok, got.ok);
      cmp_field("data_out", want.data_out, got.data_out);
      cmp_field("position", want.position, got.position);
      cmp_field("front_id", want.front_id, got.front_id);
      cmp_field("entry_count", want.entry_count, got.entry_count);
      cmp_field("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  fqs_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  fqs_out_t out_data;

  flight_queue_shadow sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  bit          filling;

  fifo_queue_with_search_top #(
    .DEPTH    (QDEPTH),
    .ID_WIDTH (ID_PORT_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= chance(recv_stall_pct);
  end

  // check every delivered reply
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) sb.check_reply(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, idling first at random, and note it once taken
  task automatic send_request(input fqs_req_t op, input logic [ID_PORT_W-1:0] id);
    fqs_in_t r;
    r.req_type  = op;
    r.flight_id = id;
    @(negedge clk);
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      in_data  <= {2'($urandom_range(3)), 16'($urandom)};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.predict_reply(r);
  endtask

  // hold off the sender until every pending reply is back
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
  endtask

  // mix of full-range ids and a narrow set that produces duplicates
  function automatic logic [ID_PORT_W-1:0] pick_id();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(7));
      1:       return chance(50) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // search target mostly taken from the current contents
  function automatic logic [ID_PORT_W-1:0] pick_target();
    if (sb.held != 0 && chance(60))
      return sb.ring[(sb.head + $urandom_range(sb.held - 1)) % QDEPTH];
    return pick_id();
  endfunction

  // one random request, biased toward filling or draining
  task automatic send_random();
    int unsigned roll;
    if (sb.held == QDEPTH && chance(70)) filling = 1'b0;
    if (sb.held == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < (filling ? 55 : 20))
      send_request(REQ_ENQ, pick_id());
    else if (roll < (filling ? 70 : 65))
      send_request(REQ_DEQ, pick_id());
    else if (roll < 97)
      send_request(REQ_SEARCH, pick_target());
    else
      send_request(REQ_CLEAR, pick_id());
  endtask

  initial begin
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    send_pct = '{0, 60, 0, 14};
    recv_pct = '{0, 0, 60, 14};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    filling        = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, fill to full, overflow, search ends, clear
    send_request(REQ_DEQ, 16'h1234);
    send_request(REQ_SEARCH, 16'h0000);
    send_request(REQ_CLEAR, 16'hFFFF);
    for (int i = 0; i < QDEPTH; i++) begin
      if (i == 0)
        send_request(REQ_ENQ, 16'hFFFF);
      else if (i == 1)
        send_request(REQ_ENQ, 16'h0000);
      else if (i == QDEPTH - 1)
        send_request(REQ_ENQ, 16'hA5A5);
      else
        send_request(REQ_ENQ, {8'(i), ~8'(i)});
    end
    send_request(REQ_ENQ, 16'h5A5A);
    send_request(REQ_SEARCH, 16'hA5A5);
    send_request(REQ_SEARCH, 16'h0000);
    send_request(REQ_DEQ, 16'h0000);
    send_request(REQ_SEARCH, 16'h5A5A);
    send_request(REQ_CLEAR, 16'h0000);
    drain_replies();

    // random traffic under each idling pattern
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
      drain_replies();
    end

    recv_stall_pct = 0;
    repeat (30) @(posedge clk);
    if (sb.failures == 0 && sb.awaited_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fqs_front.sv
rtl/fqs_back.sv
rtl/fifo_queue_with_search_top.sv
test/tb.sv
